// ===== hdl/cwtc_pkg.sv =====
`timescale 1ns / 1ps

package cwtc_pkg;

  // Fixed field widths of the access and result words.
  localparam int ADDR_W   = 32;
  localparam int SET_F_W  = 8;
  localparam int OFF_F_W  = 6;
  localparam int VICT_F_W = 26;

  // Packed widths of the stream data buses, rounded up to whole bytes.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_BITS   = 1 + 1 + SET_F_W + OFF_F_W + 1 + VICT_F_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Organisation of the cache.
  localparam int WAYS                = 2;
  localparam int DEFAULT_SETS        = 256;
  localparam int DEFAULT_BLOCK_BYTES = 64;

  // Access kind carried in tuser.
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } cwtc_op_t;

  // Outcome of one tag lookup.
  typedef struct packed {
    logic hit;
    logic way;
    logic evict;
    logic writeback;
  } cwtc_status_t;

endpackage

// ===== hdl/cwtc_lookup.sv =====
`timescale 1ns / 1ps

module cwtc_lookup
  import cwtc_pkg::*;
#(
  parameter int TAG_W = 18
) (
  input  logic [TAG_W-1:0]            tag,
  input  cwtc_op_t                    op,
  input  logic [WAYS-1:0][TAG_W-1:0]  way_tags,
  input  logic [WAYS-1:0]             way_valid,
  input  logic [WAYS-1:0]             way_dirty,
  input  logic                        lru,
  output cwtc_status_t                status,
  output logic [TAG_W-1:0]            victim_tag,
  output logic [WAYS-1:0][TAG_W-1:0]  new_tags,
  output logic [WAYS-1:0]             new_valid,
  output logic [WAYS-1:0]             new_dirty,
  output logic                        new_lru
);

  logic [WAYS-1:0] match;
  logic            hit;
  logic            use_way;
  logic            evict;
  logic            wr;

  // Compare both ways of the set at once.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = way_valid[w] && (way_tags[w] == tag);
    end
  end

  assign hit = |match;
  assign wr  = (op == OP_WRITE);

  // A hit takes the matching way, a miss the lowest invalid way, else the LRU way.
  always_comb begin
    priority if (match[0]) begin
      use_way = 1'b0;
    end else if (match[1]) begin
      use_way = 1'b1;
    end else if (!way_valid[0]) begin
      use_way = 1'b0;
    end else if (!way_valid[1]) begin
      use_way = 1'b1;
    end else begin
      use_way = lru;
    end
  end

  assign evict      = !hit && (&way_valid);
  assign victim_tag = way_tags[use_way];

  assign status.hit       = hit;
  assign status.way       = use_way;
  assign status.evict     = evict;
  assign status.writeback = evict && way_dirty[use_way];

  // Updated line state: a miss refills the chosen way, a write marks it dirty.
  always_comb begin
    new_tags  = way_tags;
    new_valid = way_valid;
    new_dirty = way_dirty;
    if (!hit) begin
      new_tags[use_way]  = tag;
      new_valid[use_way] = 1'b1;
      new_dirty[use_way] = wr;
    end else if (wr) begin
      new_dirty[use_way] = 1'b1;
    end
  end

  assign new_lru = ~use_way;

endmodule

// ===== hdl/two_way_cache_tag_controller.sv =====
`timescale 1ns / 1ps
// Pipeline: the lookup stage register, then the output register. Throughput: one access
// per cycle unless the output stalls; the set memory has one read and one write port,
// and a one-entry bypass covers a set written in the same cycle as it is read.
// Reset: synchronous; clears the pipeline, the output register and one init flag
// per set at once, so no clearing pass is needed and an access may follow at once.
module two_way_cache_tag_controller
  import cwtc_pkg::*;
#(
  parameter int SETS        = DEFAULT_SETS,
  parameter int BLOCK_BYTES = DEFAULT_BLOCK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] address
  input  logic                  s_tuser,   // [0] opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [0] hit, [1] way, [9:2] set_no,
                                           // [15:10] word_offset, [16] writeback_needed,
                                           // [42:17] victim_block, [47:43] zero
);

  localparam int SET_W = $clog2(SETS);
  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int TAG_W = ADDR_W - SET_W - OFF_W;
  localparam int BLK_W = TAG_W + SET_W;
  // Row layout: tags, valid bits, dirty bits, LRU bit.
  localparam int VAL_LO = WAYS * TAG_W;
  localparam int DIR_LO = VAL_LO + WAYS;
  localparam int LRU_B  = DIR_LO + WAYS;
  localparam int ROW_W  = LRU_B + 1;

  logic                 in_accept;
  logic                 s1_fire;
  logic                 s1_valid;
  logic [TAG_W-1:0]     s1_tag;
  logic [SET_W-1:0]     s1_set;
  logic [OFF_W-1:0]     s1_off;
  cwtc_op_t             s1_op;

  logic [ROW_W-1:0]     set_mem [SETS];
  logic [ROW_W-1:0]     rd_row;
  logic [SETS-1:0]      row_init;
  logic [ROW_W-1:0]     cur_row;
  logic [ROW_W-1:0]     new_row;

  logic                 byp_valid;
  logic [SET_W-1:0]     byp_set;
  logic [ROW_W-1:0]     byp_row;

  cwtc_status_t                status;
  logic [TAG_W-1:0]            victim_tag;
  logic [WAYS-1:0][TAG_W-1:0]  new_tags;
  logic [WAYS-1:0]             new_valid;
  logic [WAYS-1:0]             new_dirty;
  logic                        new_lru;
  logic [BLK_W-1:0]            victim_blk;

  logic                 out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // Handshake: the lookup stage moves whenever the output register is free or drains.
  assign s1_fire   = s1_valid && (!out_valid || m_tready);
  assign s_tready  = !s1_valid || s1_fire;
  assign in_accept = s_tvalid && s_tready;

  // Lookup stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  // Lookup stage payload and registered read of the set row.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tag <= s_tdata[ADDR_W-1 -: TAG_W];
      s1_set <= s_tdata[OFF_W +: SET_W];
      s1_off <= s_tdata[OFF_W-1:0];
      s1_op  <= cwtc_op_t'(s_tuser);
      rd_row <= set_mem[s_tdata[OFF_W +: SET_W]];
    end
  end

  // Write back the updated row of the set.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      set_mem[s1_set] <= new_row;
    end
  end

  // One init flag per set; an uninitialised set reads as all ways invalid.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (s1_fire) begin
      row_init[s1_set] <= 1'b1;
    end
  end

  // Bypass for a row written at the same edge as the next access read it.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (in_accept) begin
      byp_valid <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      byp_set <= s1_set;
      byp_row <= new_row;
    end
  end

  // Pick the freshest copy of the set row.
  always_comb begin
    priority if (byp_valid && (byp_set == s1_set)) begin
      cur_row = byp_row;
    end else if (row_init[s1_set]) begin
      cur_row = rd_row;
    end else begin
      cur_row = '0;
    end
  end

  cwtc_lookup #(
    .TAG_W (TAG_W)
  ) u_lookup (
    .tag        (s1_tag),
    .op         (s1_op),
    .way_tags   (cur_row[VAL_LO-1:0]),
    .way_valid  (cur_row[DIR_LO-1:VAL_LO]),
    .way_dirty  (cur_row[LRU_B-1:DIR_LO]),
    .lru        (cur_row[LRU_B]),
    .status     (status),
    .victim_tag (victim_tag),
    .new_tags   (new_tags),
    .new_valid  (new_valid),
    .new_dirty  (new_dirty),
    .new_lru    (new_lru)
  );

  assign new_row    = {new_lru, new_dirty, new_valid, new_tags};
  assign victim_blk = status.evict ? {victim_tag, s1_set} : '0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= OUT_DATA_W'({VICT_F_W'(victim_blk), status.writeback,
                               OFF_F_W'(s1_off), SET_F_W'(s1_set),
                               status.way, status.hit});
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== hdl/cwtc_checker.sv =====
`timescale 1ns / 1ps

module cwtc_checker
  import cwtc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[16] && (m_tdata[42:17] == '0))
    else $error("hit reported with a victim");

  // A fresh result word follows an accepted access.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result word without a matching access");

endmodule

bind two_way_cache_tag_controller cwtc_checker u_cwtc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
